/* rtl/mspf_pkg.sv */
// Shared types, constants and helper function of the magnetoelectric spin pair field block.
`timescale 1ns / 1ps
package mspf_pkg;

  localparam int DispW  = 24;
  localparam int SpinW  = 16;
  localparam int RsqW   = 48;
  localparam int CutW   = 50;
  localparam int FieldW = 32;
  localparam int CountW = 11;

  // One classified neighbor pair as it travels from the front to the back.
  typedef struct packed {
    logic signed [DispW-1:0] dx;
    logic signed [DispW-1:0] dy;
    logic signed [DispW-1:0] dz;
    logic signed [SpinW-1:0] ox;
    logic signed [SpinW-1:0] oy;
    logic signed [SpinW-1:0] oz;
    logic signed [SpinW-1:0] nx;
    logic signed [SpinW-1:0] ny;
    logic signed [SpinW-1:0] nz;
    logic                    last;
    logic [RsqW-1:0]         rsq;
    logic                    zero;
    logic                    in_range;
  } item_t;

  // Configuration seen by the back end.
  typedef struct packed {
    logic signed [31:0] coupling;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [30:0]        energy_scale;
    logic               energy_enable;
  } cfg_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [FieldW-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return v[FieldW-1:0];
  endfunction

endpackage

/* rtl/magnetoelectric_spin_pair_field_top.sv */
// Top level of the magnetoelectric spin pair field block.
`timescale 1ns / 1ps
// Usage:
// Each input item is one neighbor pair of a central atom: displacement, both
// spins and a last-neighbor mark. An item is taken when push is high and full
// is low. A two-entry queue behind the front end holds classified pairs, so
// the front keeps taking items while the back end works or a result waits.
// The back end handles one pair at a time. An in-range pair passes through the
// bit-pair square root, a setup step, the three-lane divider and 15 steps of
// the shared multiplier (19 with energy enabled), plus a step to take the pair
// and one to finish it. Zero-distance and out-of-range pairs skip the root,
// the divider and the multiplier. The multiplier sequence and the root set
// the rate. A result appears only for a last-neighbor item; it sits on the
// result ports while empty is low and leaves when pop is high. While it waits,
// a later last-neighbor item holds the back end and the queue fills, then full
// rises. Configuration registers are written through wr_en, wr_index and
// wr_data; the user must write them only while the block is idle, which the
// block does not enforce. Reset clears registers, sums, queue and result.
module magnetoelectric_spin_pair_field_top #(
  parameter int MaxNeighbors = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [49:0]        wr_data,
  input  logic               push,
  output logic               full,
  input  logic signed [23:0] disp_x,
  input  logic signed [23:0] disp_y,
  input  logic signed [23:0] disp_z,
  input  logic signed [15:0] own_spin_x,
  input  logic signed [15:0] own_spin_y,
  input  logic signed [15:0] own_spin_z,
  input  logic signed [15:0] nb_spin_x,
  input  logic signed [15:0] nb_spin_y,
  input  logic signed [15:0] nb_spin_z,
  input  logic               last_neighbor,
  input  logic               pop,
  output logic               empty,
  output logic signed [31:0] field_x,
  output logic signed [31:0] field_y,
  output logic signed [31:0] field_z,
  output logic signed [31:0] energy,
  output logic [10:0]        pairs_in_range,
  output logic               zero_distance
);

  localparam logic [2:0] RegCoupling = 3'd0;
  localparam logic [2:0] RegDirX     = 3'd1;
  localparam logic [2:0] RegDirY     = 3'd2;
  localparam logic [2:0] RegDirZ     = 3'd3;
  localparam logic [2:0] RegCutoff   = 3'd4;
  localparam logic [2:0] RegScale    = 3'd5;
  localparam logic [2:0] RegEnable   = 3'd6;

  mspf_pkg::cfg_t  cfg;
  logic [49:0]     cutoff_squared;
  mspf_pkg::item_t front_item;
  mspf_pkg::item_t q_item;
  logic            q_empty;
  logic            q_rd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg            <= '0;
      cutoff_squared <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        RegCoupling: cfg.coupling      <= wr_data[31:0];
        RegDirX:     cfg.dir_x         <= wr_data[15:0];
        RegDirY:     cfg.dir_y         <= wr_data[15:0];
        RegDirZ:     cfg.dir_z         <= wr_data[15:0];
        RegCutoff:   cutoff_squared    <= wr_data;
        RegScale:    cfg.energy_scale  <= wr_data[30:0];
        RegEnable:   cfg.energy_enable <= wr_data[0];
        default: ;
      endcase
    end
  end

  mspf_front u_front (
    .disp_x         (disp_x),
    .disp_y         (disp_y),
    .disp_z         (disp_z),
    .own_spin_x     (own_spin_x),
    .own_spin_y     (own_spin_y),
    .own_spin_z     (own_spin_z),
    .nb_spin_x      (nb_spin_x),
    .nb_spin_y      (nb_spin_y),
    .nb_spin_z      (nb_spin_z),
    .last_neighbor  (last_neighbor),
    .cutoff_squared (cutoff_squared),
    .item           (front_item)
  );

  mspf_fifo #(
    .Depth (2)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_item (front_item),
    .full    (full),
    .rd      (q_rd),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  mspf_back #(
    .MaxNeighbors (MaxNeighbors)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .q_item         (q_item),
    .q_rd           (q_rd),
    .pop            (pop),
    .empty          (empty),
    .field_x        (field_x),
    .field_y        (field_y),
    .field_z        (field_z),
    .energy         (energy),
    .pairs_in_range (pairs_in_range),
    .zero_distance  (zero_distance)
  );

endmodule

/* rtl/mspf_front.sv */
// Front end: forms the squared distance of a pair and classifies it.
`timescale 1ns / 1ps
module mspf_front (
  input  logic signed [23:0] disp_x,
  input  logic signed [23:0] disp_y,
  input  logic signed [23:0] disp_z,
  input  logic signed [15:0] own_spin_x,
  input  logic signed [15:0] own_spin_y,
  input  logic signed [15:0] own_spin_z,
  input  logic signed [15:0] nb_spin_x,
  input  logic signed [15:0] nb_spin_y,
  input  logic signed [15:0] nb_spin_z,
  input  logic               last_neighbor,
  input  logic [49:0]        cutoff_squared,
  output mspf_pkg::item_t    item
);

  logic signed [47:0] sq_x;
  logic signed [47:0] sq_y;
  logic signed [47:0] sq_z;
  logic [47:0]        rsq;

  // Squares are at most 2^46 each, so the sum of three fits 48 bits.
  assign sq_x = 48'(disp_x) * 48'(disp_x);
  assign sq_y = 48'(disp_y) * 48'(disp_y);
  assign sq_z = 48'(disp_z) * 48'(disp_z);
  assign rsq  = 48'(sq_x) + 48'(sq_y) + 48'(sq_z);

  // Pack the pair with its class for the queue.
  always_comb begin
    item.dx       = disp_x;
    item.dy       = disp_y;
    item.dz       = disp_z;
    item.ox       = own_spin_x;
    item.oy       = own_spin_y;
    item.oz       = own_spin_z;
    item.nx       = nb_spin_x;
    item.ny       = nb_spin_y;
    item.nz       = nb_spin_z;
    item.last     = last_neighbor;
    item.rsq      = rsq;
    item.zero     = (rsq == '0);
    item.in_range = (rsq != '0) && ({2'b00, rsq} <= cutoff_squared);
  end

endmodule

/* rtl/mspf_fifo.sv */
// Short queue of classified pairs between the front and the back end.
`timescale 1ns / 1ps
module mspf_fifo #(
  parameter int Depth = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  mspf_pkg::item_t wr_item,
  output logic            full,
  input  logic            rd,
  output mspf_pkg::item_t rd_item,
  output logic            empty
);

  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  mspf_pkg::item_t    entries [Depth];
  logic [AddrW-1:0]   wr_ptr;
  logic [AddrW-1:0]   rd_ptr;
  logic [CountW-1:0]  count;
  logic               do_wr;
  logic               do_rd;

  assign full    = (count == CountW'(Depth));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_item = entries[rd_ptr];

  // Payload storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AddrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AddrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(Depth))
    else $error("queue count above depth");

  // A write on a full queue leaves the count unchanged unless a read frees room.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (full && wr && !rd) |=> (count == CountW'(Depth)))
    else $error("queue overflowed");

  // A read of the only entry empties the queue when nothing is written.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (count == CountW'(1) && rd && !wr) |=> empty)
    else $error("queue did not drain");

endmodule

/* rtl/mspf_back.sv */
// Back end: square root, unit vector division, field and energy sequence, sums and result.
`timescale 1ns / 1ps
module mspf_back #(
  parameter int MaxNeighbors = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  mspf_pkg::cfg_t     cfg,
  input  logic               q_empty,
  input  mspf_pkg::item_t    q_item,
  output logic               q_rd,
  input  logic               pop,
  output logic               empty,
  output logic signed [31:0] field_x,
  output logic signed [31:0] field_y,
  output logic signed [31:0] field_z,
  output logic signed [31:0] energy,
  output logic [10:0]        pairs_in_range,
  output logic               zero_distance
);

  localparam int CountCap = (MaxNeighbors < 2047) ? MaxNeighbors : 2047;

  // Multiply sequence steps with a control meaning.
  localparam logic [4:0] StepLast   = 5'd18;
  localparam logic [4:0] StepFieldZ = 5'd14;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SQRT = 6'b000010,
    S_PREP = 6'b000100,
    S_DIV  = 6'b001000,
    S_MAC  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t              state;
  mspf_pkg::item_t     cur;
  logic [4:0]          cnt;
  logic [47:0]         sq_x;
  logic [47:0]         sq_res;
  logic [47:0]         sq_bit;
  logic [47:0]         sq_x_next;
  logic [47:0]         sq_res_next;
  logic [47:0]         sq_trial;
  logic [23:0]         root;
  logic [23:0]         rem   [3];
  logic [14:0]         numlo [3];
  logic [14:0]         quo   [3];
  logic [24:0]         dtrial [3];
  logic [23:0]         dabs  [3];
  logic [37:0]         dnum  [3];
  logic signed [23:0]  dsel  [3];
  logic signed [15:0]  ex, ey, ez;
  logic signed [32:0]  cx, cy, cz;
  logic signed [35:0]  mx, my, mz;
  logic signed [31:0]  hx, hy, hz;
  logic signed [31:0]  dot;
  logic signed [63:0]  acc;
  logic signed [35:0]  opa, opb;
  logic                first, negate;
  logic signed [71:0]  prod;
  logic signed [63:0]  acc_new;
  logic signed [63:0]  r28, r14, r16;
  logic signed [31:0]  h_new;
  logic signed [31:0]  en_new;
  logic signed [31:0]  sum_field_x, sum_field_y, sum_field_z, sum_energy;
  logic [10:0]         range_count;
  logic                zero_seen;
  logic                out_valid;
  logic                emit;

  assign empty = !out_valid;
  assign q_rd  = (state == S_IDLE) && !q_empty;
  assign emit  = (state == S_FIN) && cur.last && (!out_valid || pop);

  // One digit pair of the integer square root per cycle.
  assign sq_trial = sq_res + sq_bit;
  always_comb begin
    if (sq_x >= sq_trial) begin
      sq_x_next   = sq_x - sq_trial;
      sq_res_next = (sq_res >> 1) + sq_bit;
    end else begin
      sq_x_next   = sq_x;
      sq_res_next = sq_res >> 1;
    end
  end

  // Divider lanes: numerator |d| * 2^14 + r/2, one quotient bit per cycle.
  assign dsel[0] = cur.dx;
  assign dsel[1] = cur.dy;
  assign dsel[2] = cur.dz;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dabs[k]   = dsel[k][23] ? 24'(-dsel[k]) : 24'(dsel[k]);
      dnum[k]   = {dabs[k], 14'b0} + 38'(root >> 1);
      dtrial[k] = {rem[k], numlo[k][14]};
    end
  end

  // Unit bond vector points opposite to the pair displacement.
  assign ex = cur.dx[23] ? 16'({1'b0, quo[0]}) : -16'({1'b0, quo[0]});
  assign ey = cur.dy[23] ? 16'({1'b0, quo[1]}) : -16'({1'b0, quo[1]});
  assign ez = cur.dz[23] ? 16'({1'b0, quo[2]}) : -16'({1'b0, quo[2]});

  // Operand table of the shared multiplier.
  always_comb begin
    opa    = '0;
    opb    = '0;
    first  = 1'b0;
    negate = 1'b0;
    case (cnt)
      5'd0:  begin opa = 36'(cfg.dir_y); opb = 36'(ez); first = 1'b1; end
      5'd1:  begin opa = 36'(cfg.dir_z); opb = 36'(ey); negate = 1'b1; end
      5'd2:  begin opa = 36'(cfg.dir_z); opb = 36'(ex); first = 1'b1; end
      5'd3:  begin opa = 36'(cfg.dir_x); opb = 36'(ez); negate = 1'b1; end
      5'd4:  begin opa = 36'(cfg.dir_x); opb = 36'(ey); first = 1'b1; end
      5'd5:  begin opa = 36'(cfg.dir_y); opb = 36'(ex); negate = 1'b1; end
      5'd6:  begin opa = 36'(cx); opb = 36'(cfg.coupling); first = 1'b1; end
      5'd7:  begin opa = 36'(cy); opb = 36'(cfg.coupling); first = 1'b1; end
      5'd8:  begin opa = 36'(cz); opb = 36'(cfg.coupling); first = 1'b1; end
      5'd9:  begin opa = 36'(cur.ny); opb = mz; first = 1'b1; end
      5'd10: begin opa = 36'(cur.nz); opb = my; negate = 1'b1; end
      5'd11: begin opa = 36'(cur.nz); opb = mx; first = 1'b1; end
      5'd12: begin opa = 36'(cur.nx); opb = mz; negate = 1'b1; end
      5'd13: begin opa = 36'(cur.nx); opb = my; first = 1'b1; end
      5'd14: begin opa = 36'(cur.ny); opb = mx; negate = 1'b1; end
      5'd15: begin opa = 36'(cur.ox); opb = 36'(hx); first = 1'b1; end
      5'd16: begin opa = 36'(cur.oy); opb = 36'(hy); end
      5'd17: begin opa = 36'(cur.oz); opb = 36'(hz); end
      5'd18: begin opa = 36'(dot); opb = 36'({1'b0, cfg.energy_scale}); first = 1'b1; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // Multiply, accumulate and the rounded views of the new total.
  assign prod    = 72'(opa) * 72'(opb);
  assign acc_new = (first ? 64'sd0 : acc) + (negate ? -prod[63:0] : prod[63:0]);
  assign r28     = (acc_new + 64'sd134217728) >>> 28;
  assign r14     = (acc_new + 64'sd8192) >>> 14;
  assign r16     = (acc_new + 64'sd32768) >>> 16;
  assign h_new   = mspf_pkg::sat32(r14);
  assign en_new  = mspf_pkg::sat32(-r16);

  // Datapath registers of the current pair.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cur    <= q_item;
        sq_x   <= q_item.rsq;
        sq_res <= '0;
        sq_bit <= 48'h4000_0000_0000;
      end
      S_SQRT: begin
        sq_x   <= sq_x_next;
        sq_res <= sq_res_next;
        sq_bit <= sq_bit >> 2;
        root   <= sq_res_next[23:0];
      end
      S_PREP: begin
        for (int k = 0; k < 3; k++) begin
          rem[k]   <= {1'b0, dnum[k][37:15]};
          numlo[k] <= dnum[k][14:0];
          quo[k]   <= '0;
        end
      end
      S_DIV: begin
        for (int k = 0; k < 3; k++) begin
          if (dtrial[k] >= {1'b0, root}) begin
            rem[k] <= 24'(dtrial[k] - {1'b0, root});
            quo[k] <= {quo[k][13:0], 1'b1};
          end else begin
            rem[k] <= dtrial[k][23:0];
            quo[k] <= {quo[k][13:0], 1'b0};
          end
          numlo[k] <= {numlo[k][13:0], 1'b0};
        end
      end
      S_MAC: begin
        acc <= acc_new;
        case (cnt)
          5'd1:  cx  <= acc_new[32:0];
          5'd3:  cy  <= acc_new[32:0];
          5'd5:  cz  <= acc_new[32:0];
          5'd6:  mx  <= r28[35:0];
          5'd7:  my  <= r28[35:0];
          5'd8:  mz  <= r28[35:0];
          5'd10: hx  <= h_new;
          5'd12: hy  <= h_new;
          5'd14: hz  <= h_new;
          5'd17: dot <= h_new;
          default: ;
        endcase
      end
      S_FIN: ;
      default: ;
    endcase
  end

  // Sequencer, sums and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      sum_field_x <= '0;
      sum_field_y <= '0;
      sum_field_z <= '0;
      sum_energy  <= '0;
      range_count <= '0;
      zero_seen   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_item.zero) begin
              zero_seen <= 1'b1;
            end
            cnt   <= 5'd23;
            state <= q_item.in_range ? S_SQRT : S_FIN;
          end
        end
        S_SQRT: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          cnt   <= 5'd14;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            cnt   <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          cnt <= cnt + 1'b1;
          if (cnt == StepFieldZ) begin
            sum_field_x <= mspf_pkg::sat32(64'(sum_field_x) + 64'(hx));
            sum_field_y <= mspf_pkg::sat32(64'(sum_field_y) + 64'(hy));
            sum_field_z <= mspf_pkg::sat32(64'(sum_field_z) + 64'(h_new));
            if (range_count < 11'(CountCap)) begin
              range_count <= range_count + 1'b1;
            end
            if (!cfg.energy_enable) begin
              state <= S_FIN;
            end
          end
          if (cnt == StepLast) begin
            sum_energy <= mspf_pkg::sat32(64'(sum_energy) + 64'(en_new));
            state      <= S_FIN;
          end
        end
        S_FIN: begin
          if (!cur.last) begin
            state <= S_IDLE;
          end else if (emit) begin
            out_valid   <= 1'b1;
            sum_field_x <= '0;
            sum_field_y <= '0;
            sum_field_z <= '0;
            sum_energy  <= '0;
            range_count <= '0;
            zero_seen   <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result payload is loaded together with the valid flag.
  always_ff @(posedge clk) begin
    if (emit) begin
      field_x        <= sum_field_x;
      field_y        <= sum_field_y;
      field_z        <= sum_field_z;
      energy         <= sum_energy;
      pairs_in_range <= range_count;
      zero_distance  <= zero_seen;
    end
  end

  // A pending result is never overwritten before it is taken.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && cur.last && out_valid && !pop) |=> (state == S_FIN && out_valid))
    else $error("result overwritten");

  // The pair count stays at or below its cap.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    range_count <= 11'(CountCap))
    else $error("pair count above cap");

  // Unit vector components never exceed one.
  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC) |-> (quo[0] <= 15'd16384 && quo[1] <= 15'd16384 && quo[2] <= 15'd16384))
    else $error("unit component out of range");

  // Emitting a result clears the sums.
  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    emit |=> (range_count == '0 && !zero_seen && sum_energy == '0))
    else $error("sums not cleared");

endmodule
